// ===== rtl/core/lhk_pkg.sv =====
// Shared types, constants and fixed-point helpers of the Langevin half-kick integrator.
package lhk_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int TIME_W    = 48;
  localparam int MUL_B_W   = WORD_W + 1;
  localparam int PROD_W    = 2 * MUL_B_W;
  localparam int DIV_W     = 3 * FRAC_BITS + 1;
  localparam int STR_W     = FRAC_BITS + 1;
  localparam int CFG_IDX_W = 3;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [WORD_W-1:0] TIME_STEP_RST = 32'd655;
  localparam logic [WORD_W-1:0] TEMP_RST      = 32'd1638;
  localparam logic [WORD_W-1:0] VISC_RST      = 32'd65536;
  localparam logic [WORD_W-1:0] DRIFT_RST     = 32'd0;
  localparam logic [WORD_W-1:0] DELAY_RST     = 32'd0;

  localparam logic [TIME_W-1:0] RNG_SEED  = 48'h1234ABCD330E;
  localparam logic [WORD_W-1:0] LCG_A_LO  = 32'hDEECE66D;
  localparam logic [15:0]       LCG_A_HI  = 16'd5;
  localparam logic [TIME_W-1:0] LCG_C     = 48'hB;

  localparam logic [63:0] PI_Q32 = 64'd13493037705;
  localparam logic [WORD_W-1:0] SIX_PI =
    WORD_W'((64'd6 * PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));

  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [PROD_W-1:0] U32_MAX  = PROD_W'(64'hFFFF_FFFF);
  localparam logic signed [PROD_W-1:0] S32_MAX  = PROD_W'(64'h7FFF_FFFF);
  localparam logic signed [PROD_W-1:0] S32_MIN  = -S32_MAX - PROD_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_STEP   = 3'd0,
    REG_TEMPERATURE = 3'd1,
    REG_VISCOSITY   = 3'd2,
    REG_DRIFT_COEF  = 3'd3,
    REG_NOISE_DELAY = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [WORD_W-1:0] time_step;
    logic [WORD_W-1:0] temperature;
    logic [WORD_W-1:0] viscosity;
    logic [WORD_W-1:0] drift_coefficient;
    logic [WORD_W-1:0] noise_delay;
  } cfg_t;

  typedef enum logic [1:0] {
    CLS_DRIFT  = 2'd0,
    CLS_DECIDE = 2'd1,
    CLS_FOLLOW = 2'd2
  } item_cls_t;

  typedef struct packed {
    item_cls_t                cls;
    logic [TIME_W-1:0]        elapsed_time;
    logic signed [WORD_W-1:0] position;
    logic signed [WORD_W-1:0] velocity;
    logic signed [WORD_W-1:0] force_req;
    logic [WORD_W-1:0]        inverse_mass;
    logic [WORD_W-1:0]        sigma;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECIDE, ST_NS_MUL_LO, ST_NS_MUL_HI, ST_NS_SUM, ST_NS_ROOT,
    ST_W_GO, ST_W_DIV, ST_W_ROOT, ST_LCG, ST_LCG_RES,
    ST_NT_MUL1, ST_NT_RES1, ST_NT_MUL2, ST_NT_RES2,
    ST_DG_MUL1, ST_DG_RES1, ST_DG_MUL2, ST_DG_RES2, ST_DG_MUL3, ST_DG_RES3,
    ST_KK_MUL1, ST_KK_RES1, ST_KK_MUL2, ST_KK_RES2,
    ST_DR_MUL, ST_DR_RES, ST_DONE
  } st_t;

  // round to nearest (ties up), drop the fraction, clamp to 32 bits unsigned
  function automatic logic [WORD_W-1:0] umul_fix(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = (p + RND_HALF) >>> FRAC_BITS;
    if (t > U32_MAX) umul_fix = '1;
    else umul_fix = t[WORD_W-1:0];
  endfunction

  // as above, clamped to 32 bits signed
  function automatic logic signed [WORD_W-1:0] smul_fix(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = (p + RND_HALF) >>> FRAC_BITS;
    if (t > S32_MAX) smul_fix = 32'sh7FFF_FFFF;
    else if (t < S32_MIN) smul_fix = 32'sh8000_0000;
    else smul_fix = t[WORD_W-1:0];
  endfunction

  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WORD_W:0] s);
    if (s > 33'sd2147483647) sat_word = 32'sh7FFF_FFFF;
    else if (s < -33'sd2147483648) sat_word = 32'sh8000_0000;
    else sat_word = s[WORD_W-1:0];
  endfunction

endpackage

// ===== rtl/core/lhk_isqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
module lhk_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] rad,
  output logic        done,
  output logic [31:0] root
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [63:0] rad_r, rad_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [34:0] rem_t;
  logic [34:0] trial;

  assign rem_t = {rem_r, rad_r[63:62]};
  assign trial = {1'b0, root_r, 2'b01};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rad_nxt  = rad;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rad_nxt = {rad_r[61:0], 2'b00};
      if (rem_t >= trial) begin
        rem_nxt  = 33'(rem_t - trial);
        root_nxt = {root_r[30:0], 1'b1};
      end else begin
        rem_nxt  = 33'(rem_t);
        root_nxt = {root_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == '1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== rtl/core/lhk_recip.sv =====
// Restoring divider forming 2^(3*FRAC_BITS) / divisor, one quotient bit per cycle.
module lhk_recip import lhk_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] divisor,
  output logic              done,
  output logic [DIV_W-1:0]  quot
);

  localparam int CNT_W = $clog2(DIV_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [WORD_W-1:0] dvs_r, dvs_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0]  q_r, q_nxt;
  logic [WORD_W:0]   rem_t;

  // only the top numerator bit is set
  assign rem_t = {rem_r, (cnt_r == '0)};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
      q_nxt    = '0;
    end else if (busy_r) begin
      if (rem_t >= {1'b0, dvs_r}) begin
        rem_nxt = WORD_W'(rem_t - {1'b0, dvs_r});
        q_nxt   = {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_t[WORD_W-1:0];
        q_nxt   = {q_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== rtl/core/lhk_front.sv =====
// Front end: classify incoming beats and queue them for the back end.
module lhk_front import lhk_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_command,
  input  logic                     in_first_of_call,
  input  logic [TIME_W-1:0]        in_elapsed_time,
  input  logic signed [WORD_W-1:0] in_position,
  input  logic signed [WORD_W-1:0] in_velocity,
  input  logic signed [WORD_W-1:0] in_force_req,
  input  logic [WORD_W-1:0]        in_inverse_mass,
  input  logic [WORD_W-1:0]        in_sigma,
  output q_head_t                  q_head,
  input  logic                     q_pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             pop;
  item_t            new_item;

  assign in_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && (count_r != '0);

  always_comb begin
    new_item.elapsed_time = in_elapsed_time;
    new_item.position     = in_position;
    new_item.velocity     = in_velocity;
    new_item.force_req    = in_force_req;
    new_item.inverse_mass = in_inverse_mass;
    new_item.sigma        = in_sigma;
    if (!in_command) new_item.cls = CLS_DRIFT;
    else if (in_first_of_call) new_item.cls = CLS_DECIDE;
    else new_item.cls = CLS_FOLLOW;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) count_nxt = count_r + CNT_W'(1);
    else if (pop && !push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) mem_r[wr_ptr_r] <= new_item;
  end

  assign q_head.valid = (count_r != '0);
  assign q_head.item  = mem_r[rd_ptr_r];

endmodule

// ===== rtl/core/lhk_back.sv =====
// Back end: sequencer around one shared multiplier, the root and divider units and the noise state.
module lhk_back import lhk_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  q_head_t                  q_head,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [WORD_W-1:0] out_position_out,
  output logic signed [WORD_W-1:0] out_velocity_out,
  output logic signed [WORD_W-1:0] out_force_out,
  output logic                     out_noise_added
);

  st_t                      st_r, st_nxt;
  item_cls_t                cls_r, cls_nxt;
  logic [TIME_W-1:0]        now_r, now_nxt;
  logic signed [WORD_W-1:0] x_r, x_nxt, v_r, v_nxt, f_r, f_nxt;
  logic [WORD_W-1:0]        im_r, im_nxt, sg_r, sg_nxt;
  logic [WORD_W-1:0]        m_r, m_nxt, w_r, w_nxt;
  logic [TIME_W-1:0]        diff_r, diff_nxt;
  logic [63:0]              acc_r, acc_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [15:0]              fold_r, fold_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic [TIME_W-1:0]        rng_r, rng_nxt;
  logic [TIME_W-1:0]        last_r, last_nxt;
  logic                     active_r, active_nxt;
  logic [WORD_W-1:0]        scale_r, scale_nxt;
  logic                     added_r, added_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [WORD_W-1:0] out_x_r, out_x_nxt, out_v_r, out_v_nxt, out_f_r, out_f_nxt;
  logic                     out_add_r, out_add_nxt;

  logic [WORD_W-1:0]         mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic                      sq_start, sq_done;
  logic [63:0]               sq_rad;
  logic [31:0]               sq_root;
  logic                      div_start, div_done;
  logic [DIV_W-1:0]          div_q;
  logic [TIME_W-1:0]         diff;
  logic                      noise_due;
  logic [80:0]               scale_sum;
  logic [15:0]               lcg_fold;
  logic signed [STR_W-1:0]   strength;

  assign mul_p = PROD_W'($signed({1'b0, mul_a}) * mul_b);

  assign diff      = now_r - last_r;
  assign noise_due = (now_r > last_r) && (diff > TIME_W'(cfg.noise_delay))
                     && (cfg.temperature != '0);
  assign scale_sum = 81'(acc_r) + {1'b0, prod_r[47:0], 32'b0};
  assign lcg_fold  = 16'(rng_r[15:0] * LCG_A_HI) + 16'(rng_r[47:32] * LCG_A_LO[15:0]);
  assign strength  = $signed({1'b0, rng_r[TIME_W-1 -: FRAC_BITS]})
                     - $signed(STR_W'(1) << (FRAC_BITS - 1));

  lhk_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .rad   (sq_rad),
    .done  (sq_done),
    .root  (sq_root)
  );

  lhk_recip u_recip (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (sg_r),
    .done    (div_done),
    .quot    (div_q)
  );

  always_comb begin
    st_nxt = st_r;     cls_nxt = cls_r;   now_nxt = now_r;
    x_nxt = x_r;       v_nxt = v_r;       f_nxt = f_r;
    im_nxt = im_r;     sg_nxt = sg_r;     m_nxt = m_r;     w_nxt = w_r;
    diff_nxt = diff_r; acc_nxt = acc_r;   ovf_nxt = ovf_r; fold_nxt = fold_r;
    rng_nxt = rng_r;   last_nxt = last_r; active_nxt = active_r;
    scale_nxt = scale_r; added_nxt = added_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_x_nxt = out_x_r; out_v_nxt = out_v_r; out_f_nxt = out_f_r; out_add_nxt = out_add_r;
    mul_a = '0;  mul_b = '0;
    q_pop = 1'b0; sq_start = 1'b0; sq_rad = '0; div_start = 1'b0;

    unique case (st_r)
      ST_IDLE: begin
        if (q_head.valid) begin
          q_pop     = 1'b1;
          cls_nxt   = q_head.item.cls;
          now_nxt   = q_head.item.elapsed_time;
          x_nxt     = q_head.item.position;
          v_nxt     = q_head.item.velocity;
          f_nxt     = q_head.item.force_req;
          im_nxt    = q_head.item.inverse_mass;
          sg_nxt    = q_head.item.sigma;
          added_nxt = 1'b0;
          unique case (q_head.item.cls)
            CLS_DRIFT:  st_nxt = ST_KK_MUL1;
            CLS_DECIDE: st_nxt = ST_DECIDE;
            CLS_FOLLOW: begin
              added_nxt = active_r;
              st_nxt    = active_r ? ST_W_GO : ST_DG_MUL1;
            end
            default:    st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DECIDE: begin
        active_nxt = noise_due;
        if (noise_due) begin
          last_nxt  = now_r;
          diff_nxt  = diff;
          added_nxt = 1'b1;
          st_nxt    = ST_NS_MUL_LO;
        end else begin
          st_nxt = ST_DG_MUL1;
        end
      end
      ST_NS_MUL_LO: begin
        mul_a  = cfg.drift_coefficient;
        mul_b  = {1'b0, diff_r[31:0]};
        st_nxt = ST_NS_MUL_HI;
      end
      ST_NS_MUL_HI: begin
        acc_nxt = prod_r[63:0];
        mul_a   = cfg.drift_coefficient;
        mul_b   = MUL_B_W'(diff_r[47:32]);
        st_nxt  = ST_NS_SUM;
      end
      ST_NS_SUM: begin
        ovf_nxt  = |scale_sum[80:63];
        sq_start = 1'b1;
        sq_rad   = {scale_sum[62:0], 1'b0};
        st_nxt   = ST_NS_ROOT;
      end
      ST_NS_ROOT: begin
        if (sq_done) begin
          scale_nxt = ovf_r ? '1 : sq_root;
          st_nxt    = ST_W_GO;
        end
      end
      ST_W_GO: begin
        if (sg_r == '0) begin
          w_nxt  = '1;
          st_nxt = ST_LCG;
        end else begin
          div_start = 1'b1;
          st_nxt    = ST_W_DIV;
        end
      end
      ST_W_DIV: begin
        if (div_done) begin
          sq_start = 1'b1;
          sq_rad   = 64'(div_q);
          ovf_nxt  = |(div_q >> 64);
          st_nxt   = ST_W_ROOT;
        end
      end
      ST_W_ROOT: begin
        if (sq_done) begin
          w_nxt  = ovf_r ? '1 : sq_root;
          st_nxt = ST_LCG;
        end
      end
      ST_LCG: begin
        mul_a    = rng_r[31:0];
        mul_b    = {1'b0, LCG_A_LO};
        fold_nxt = lcg_fold;
        st_nxt   = ST_LCG_RES;
      end
      ST_LCG_RES: begin
        rng_nxt = prod_r[47:0] + {fold_r, 32'b0} + LCG_C;
        st_nxt  = ST_NT_MUL1;
      end
      ST_NT_MUL1: begin
        mul_a  = scale_r;
        mul_b  = {1'b0, w_r};
        st_nxt = ST_NT_RES1;
      end
      ST_NT_RES1: begin
        m_nxt  = umul_fix(prod_r);
        st_nxt = ST_NT_MUL2;
      end
      ST_NT_MUL2: begin
        mul_a  = m_r;
        mul_b  = MUL_B_W'(strength);
        st_nxt = ST_NT_RES2;
      end
      ST_NT_RES2: begin
        f_nxt  = sat_word(33'(f_r) + 33'(smul_fix(prod_r)));
        st_nxt = ST_DG_MUL1;
      end
      ST_DG_MUL1: begin
        mul_a  = SIX_PI;
        mul_b  = {1'b0, cfg.viscosity};
        st_nxt = ST_DG_RES1;
      end
      ST_DG_RES1: begin
        m_nxt  = umul_fix(prod_r);
        st_nxt = ST_DG_MUL2;
      end
      ST_DG_MUL2: begin
        mul_a  = m_r;
        mul_b  = {1'b0, sg_r};
        st_nxt = ST_DG_RES2;
      end
      ST_DG_RES2: begin
        m_nxt  = umul_fix(prod_r);
        st_nxt = ST_DG_MUL3;
      end
      ST_DG_MUL3: begin
        mul_a  = m_r;
        mul_b  = MUL_B_W'(v_r);
        st_nxt = ST_DG_RES3;
      end
      ST_DG_RES3: begin
        f_nxt  = sat_word(33'(f_r) - 33'(smul_fix(prod_r)));
        st_nxt = ST_KK_MUL1;
      end
      ST_KK_MUL1: begin
        mul_a  = {1'b0, cfg.time_step[WORD_W-1:1]};
        mul_b  = {1'b0, im_r};
        st_nxt = ST_KK_RES1;
      end
      ST_KK_RES1: begin
        m_nxt  = umul_fix(prod_r);
        st_nxt = ST_KK_MUL2;
      end
      ST_KK_MUL2: begin
        mul_a  = m_r;
        mul_b  = MUL_B_W'(f_r);
        st_nxt = ST_KK_RES2;
      end
      ST_KK_RES2: begin
        v_nxt  = sat_word(33'(v_r) + 33'(smul_fix(prod_r)));
        st_nxt = (cls_r == CLS_DRIFT) ? ST_DR_MUL : ST_DONE;
      end
      ST_DR_MUL: begin
        mul_a  = cfg.time_step;
        mul_b  = MUL_B_W'(v_r);
        st_nxt = ST_DR_RES;
      end
      ST_DR_RES: begin
        x_nxt  = sat_word(33'(x_r) + 33'(smul_fix(prod_r)));
        st_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = x_r;
          out_v_nxt     = v_r;
          out_f_nxt     = f_r;
          out_add_nxt   = added_r;
          st_nxt        = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      rng_r       <= RNG_SEED;
      last_r      <= '0;
      active_r    <= 1'b0;
      scale_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      rng_r       <= rng_nxt;
      last_r      <= last_nxt;
      active_r    <= active_nxt;
      scale_r     <= scale_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cls_r   <= cls_nxt;   now_r  <= now_nxt;
    x_r     <= x_nxt;     v_r    <= v_nxt;    f_r   <= f_nxt;
    im_r    <= im_nxt;    sg_r   <= sg_nxt;
    m_r     <= m_nxt;     w_r    <= w_nxt;
    diff_r  <= diff_nxt;  acc_r  <= acc_nxt;  ovf_r <= ovf_nxt;
    fold_r  <= fold_nxt;  prod_r <= mul_p;
    added_r <= added_nxt;
    out_x_r <= out_x_nxt; out_v_r <= out_v_nxt; out_f_r <= out_f_nxt;
    out_add_r <= out_add_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_position_out = out_x_r;
  assign out_velocity_out = out_v_r;
  assign out_force_out    = out_f_r;
  assign out_noise_added  = out_add_r;

endmodule

// ===== rtl/core/langevin_half_kick_integrator_unit.sv =====
// Top level of the Langevin half-kick integrator: configuration registers and the two halves.
//
// Use: one beat on the in_ channel carries one coordinate of one particle.
// command 0 runs the half kick and drift; command 1 runs the optional
// noise kick, the Stokes drag and the second half kick. first_of_call on a
// second-pass beat decides whether noise is due for that whole call.
// The cfg_ channel writes registers by index (time step, temperature,
// viscosity, drift coefficient, noise delay); it is always ready.
// Results leave on the out_ channel, one beat per input beat, in order.
// A first-pass beat runs the half kick and drift; a second-pass beat
// runs the drag and the second half kick, after a decision step when it
// carries first_of_call. Added noise first forms the sigma weight by the
// 49-step reciprocal divide and the 32-step square root, then runs the
// generator and noise term; the beat that decides also computes the noise
// scale. One multiplier is shared by the multiply steps, so beats are
// worked one at a time.
// A two-beat queue sits in front of the engine, so input keeps flowing
// while the engine is busy or the receiver stalls, until the queue fills;
// a stalled output holds its beat until taken and the engine waits behind it.
// Reset restores the register defaults, the generator seed and the
// noise timing state, and empties the queue and the output stage.
module langevin_half_kick_integrator_unit import lhk_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_command,
  input  logic                     in_first_of_call,
  input  logic [TIME_W-1:0]        in_elapsed_time,
  input  logic signed [WORD_W-1:0] in_position,
  input  logic signed [WORD_W-1:0] in_velocity,
  input  logic signed [WORD_W-1:0] in_force_req,
  input  logic [WORD_W-1:0]        in_inverse_mass,
  input  logic [WORD_W-1:0]        in_sigma,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [WORD_W-1:0] out_position_out,
  output logic signed [WORD_W-1:0] out_velocity_out,
  output logic signed [WORD_W-1:0] out_force_out,
  output logic                     out_noise_added,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [WORD_W-1:0]        cfg_data
);

  cfg_t    cfg_r, cfg_nxt;
  q_head_t q_head;
  logic    q_pop;

  // a register write always lands, so never push back
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_TIME_STEP:   cfg_nxt.time_step         = cfg_data;
        REG_TEMPERATURE: cfg_nxt.temperature       = cfg_data;
        REG_VISCOSITY:   cfg_nxt.viscosity         = cfg_data;
        REG_DRIFT_COEF:  cfg_nxt.drift_coefficient = cfg_data;
        REG_NOISE_DELAY: cfg_nxt.noise_delay       = cfg_data;
        default:         cfg_nxt = cfg_r;   // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.time_step         <= TIME_STEP_RST;
      cfg_r.temperature       <= TEMP_RST;
      cfg_r.viscosity         <= VISC_RST;
      cfg_r.drift_coefficient <= DRIFT_RST;
      cfg_r.noise_delay       <= DELAY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lhk_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_first_of_call (in_first_of_call),
    .in_elapsed_time  (in_elapsed_time),
    .in_position      (in_position),
    .in_velocity      (in_velocity),
    .in_force_req     (in_force_req),
    .in_inverse_mass  (in_inverse_mass),
    .in_sigma         (in_sigma),
    .q_head           (q_head),
    .q_pop            (q_pop)
  );

  lhk_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_position_out (out_position_out),
    .out_velocity_out (out_velocity_out),
    .out_force_out    (out_force_out),
    .out_noise_added  (out_noise_added)
  );

endmodule

// ===== rtl/core/lhk_checker.sv =====
// Port-level checks of the integrator, bound to the top level.
module lhk_checker import lhk_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [WORD_W-1:0] out_position_out,
  input logic signed [WORD_W-1:0] out_velocity_out,
  input logic signed [WORD_W-1:0] out_force_out,
  input logic                     out_noise_added,
  input logic                     cfg_valid,
  input logic                     cfg_ready
);

  localparam int PEND_W = $clog2(QUEUE_DEPTH + 3) + 1;

  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic              in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) pend_nxt = pend_r + PEND_W'(1);
    else if (out_acc && !in_acc) pend_nxt = pend_r - PEND_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= '0;
    else pend_r <= pend_nxt;
  end

  // reset empties the queue and the output stage
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> in_ready && !out_valid)
    else $error("not empty after reset");

  // a result only for a beat that went in
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("result without a pending beat");

  // queue, engine and output stage bound the beats in flight
  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PEND_W'(QUEUE_DEPTH + 2))
    else $error("too many beats in flight");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_position_out)
      && $stable(out_velocity_out) && $stable(out_force_out) && $stable(out_noise_added))
    else $error("stalled result changed");

  // register writes are never refused
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind langevin_half_kick_integrator_unit lhk_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_lhk_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the Langevin half-kick integrator unit.
`timescale 1ns / 100ps

module tb_top;
  import lhk_pkg::*;

  typedef struct {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic signed [31:0] frc;
    logic               added;
  } kick_result_t;

  // Predicts the integrator and keeps the results still owed by the block.
  class kick_scoreboard;
    logic [31:0]  ts, temp, visc, drift, delay;
    logic [47:0]  rng, last_t;
    bit           active;
    logic [31:0]  scale;
    kick_result_t owed[$];
    int           errors;

    function new();
      ts = 32'd655; temp = 32'd1638; visc = 32'd65536; drift = 0; delay = 0;
      rng = 48'd20017429951246; last_t = 0; active = 0; scale = 0;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] d);
      case (idx)
        REG_TIME_STEP:   ts = d;
        REG_TEMPERATURE: temp = d;
        REG_VISCOSITY:   visc = d;
        REG_DRIFT_COEF:  drift = d;
        REG_NOISE_DELAY: delay = d;
        default: ;
      endcase
    endfunction

    function logic signed [31:0] fx_sat(logic signed [95:0] x);
      if (x > 96'sd2147483647) return 32'sh7FFF_FFFF;
      if (x < -96'sd2147483648) return 32'sh8000_0000;
      return x[31:0];
    endfunction

    function logic [31:0] fx_umul(logic [31:0] a, logic [31:0] b);
      logic [64:0] p;
      p = (65'(a) * 65'(b) + 65'd32768) >> 16;
      return (p > 65'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
    endfunction

    // round half up, floor on negatives, then clamp
    function logic signed [31:0] fx_smul(logic [31:0] a, logic signed [31:0] b);
      logic signed [95:0] p;
      p = $signed({64'd0, a}) * 96'(b);
      p = (p + 96'sd32768) >>> 16;
      return fx_sat(p);
    endfunction

    function logic [31:0] root_sat(logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    endfunction

    function logic signed [31:0] half_kick(logic signed [31:0] v, logic [31:0] im,
                                           logic signed [31:0] f);
      logic [31:0] k;
      k = fx_umul(ts >> 1, im);
      return fx_sat(96'(v) + 96'(fx_smul(k, f)));
    endfunction

    // note an accepted beat and queue the result it must produce
    function void note_input(bit cmd, bit first, logic [47:0] now,
                             logic signed [31:0] x, logic signed [31:0] v,
                             logic signed [31:0] f, logic [31:0] im, logic [31:0] sg);
      kick_result_t res;
      logic [47:0]  diff;
      logic [127:0] pr;
      logic [31:0]  w, m, six_pi;
      logic signed [31:0] strength;
      res.added = 0;
      if (!cmd) begin
        v = half_kick(v, im, f);
        x = fx_sat(96'(x) + 96'(fx_smul(ts, v)));
      end else begin
        if (first) begin
          diff = (now > last_t) ? now - last_t : 48'd0;
          active = (now > last_t) && (diff > {16'd0, delay}) && (temp != 0);
          if (active) begin
            pr = 128'({drift, 1'b0}) * 128'(diff);
            scale = (pr[127:64] != 0) ? 32'hFFFF_FFFF : root_sat(pr[63:0]);
            last_t = now;
          end
        end
        if (active) begin
          w = (sg == 0) ? 32'hFFFF_FFFF : root_sat((64'd1 << 48) / 64'(sg));
          rng = rng * 48'h5_DEEC_E66D + 48'hB;
          strength = $signed({16'd0, rng[47:32]}) - 32'sd32768;
          f = fx_sat(96'(f) + 96'(fx_smul(fx_umul(scale, w), strength)));
          res.added = 1;
        end
        six_pi = 32'((64'd6 * 64'd13493037705 + 64'd32768) >> 16);
        m = fx_umul(fx_umul(six_pi, visc), sg);
        f = fx_sat(96'(f) - 96'(fx_smul(m, v)));
        v = half_kick(v, im, f);
      end
      res.pos = x;
      res.vel = v;
      res.frc = f;
      owed.push_back(res);
    endfunction

    function void check_result(logic signed [31:0] pos, logic signed [31:0] vel,
                               logic signed [31:0] frc, logic added);
      kick_result_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result pos=%0d vel=%0d frc=%0d", $time, pos, vel, frc);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (pos !== e.pos) begin
        $display("%0t: position_out expected %0d got %0d", $time, e.pos, pos);
        errors++;
      end
      if (vel !== e.vel) begin
        $display("%0t: velocity_out expected %0d got %0d", $time, e.vel, vel);
        errors++;
      end
      if (frc !== e.frc) begin
        $display("%0t: force_out expected %0d got %0d", $time, e.frc, frc);
        errors++;
      end
      if (added !== e.added) begin
        $display("%0t: noise_added expected %0b got %0b", $time, e.added, added);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_ready;
  logic in_command = 0, in_first_of_call = 0;
  logic [47:0] in_elapsed_time = 0;
  logic signed [31:0] in_position = 0, in_velocity = 0, in_force_req = 0;
  logic [31:0] in_inverse_mass = 0, in_sigma = 0;
  logic out_valid, out_ready = 0;
  logic signed [31:0] out_position_out, out_velocity_out, out_force_out;
  logic out_noise_added;
  logic cfg_valid = 0, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;

  // 0 none, 1 sender idles, 2 receiver stalls, 3 both
  int idle_mode = 0;
  logic [47:0] sim_now = 0;
  kick_scoreboard sb = new();

  langevin_half_kick_integrator_unit DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // receiver: choose ready on the falling edge
  always @(negedge clk) begin
    if (idle_mode == 2) out_ready = ($urandom_range(0, 99) >= 75);
    else if (idle_mode == 3) out_ready = ($urandom_range(0, 99) >= 34);
    else out_ready = 1;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_position_out, out_velocity_out, out_force_out, out_noise_added);
  end

  task automatic wait_drained();
    while (sb.owed.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] d);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data  = d;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic write_all(logic [31:0] t, logic [31:0] tp, logic [31:0] vi,
                           logic [31:0] dr, logic [31:0] dl);
    write_reg(REG_TIME_STEP, t);
    write_reg(REG_TEMPERATURE, tp);
    write_reg(REG_VISCOSITY, vi);
    write_reg(REG_DRIFT_COEF, dr);
    write_reg(REG_NOISE_DELAY, dl);
  endtask

  // present one beat from a falling edge and hold it until taken
  task automatic send(bit cmd, bit first, logic [47:0] t, logic [31:0] x, logic [31:0] v,
                      logic [31:0] f, logic [31:0] im, logic [31:0] sg);
    if (idle_mode == 1) while ($urandom_range(0, 99) < 75) @(negedge clk);
    if (idle_mode == 3) while ($urandom_range(0, 99) < 34) @(negedge clk);
    in_valid = 1;
    in_command = cmd;
    in_first_of_call = first;
    in_elapsed_time = t;
    in_position = x;
    in_velocity = v;
    in_force_req = f;
    in_inverse_mass = im;
    in_sigma = sg;
    do @(posedge clk); while (!in_ready);
    sb.note_input(cmd, first, t, x, v, f, im, sg);
    @(negedge clk);
    in_valid = 0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      2: case ($urandom_range(0, 3))
           0: return 32'h7FFF_FFFF;
           1: return 32'h8000_0000;
           2: return 32'h0;
           default: return 32'hFFFF_FFFF;
         endcase
      default: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
    endcase
  endfunction

  function automatic logic [31:0] pick_mass();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return $urandom_range(1 << 12, 1 << 19);
  endfunction

  // advance the clock of the simulated system, now and then jump back or far
  function automatic logic [47:0] next_time();
    case ($urandom_range(0, 9))
      0: sim_now = sim_now - $urandom_range(0, 1 << 16);
      1: sim_now = {$urandom, $urandom} >> 16;
      default: sim_now = sim_now + $urandom_range(0, 1 << 18);
    endcase
    return sim_now;
  endfunction

  task automatic random_phase(int count, bit hold_off);
    int sent;
    int n;
    logic [31:0] xs[3], vs[3], fs[3];
    logic [31:0] im, sg;
    logic [47:0] t;
    sent = 0;
    while (sent < count) begin
      if (hold_off && sent >= count / 2) begin
        wait_drained();
        hold_off = 0;
      end
      if ($urandom_range(0, 9) < 8) begin
        // one call: first pass over the coordinates, then second pass
        n = $urandom_range(1, 3);
        im = pick_mass();
        sg = ($urandom_range(0, 19) == 0) ? $urandom : pick_mass();
        for (int i = 0; i < n; i++) begin
          xs[i] = pick_value(); vs[i] = pick_value(); fs[i] = pick_value();
          send(0, $urandom_range(0, 1), $urandom, xs[i], vs[i], fs[i], im, sg);
        end
        t = next_time();
        for (int i = 0; i < n; i++)
          send(1, i == 0, (i == 0) ? t : 48'({$urandom, $urandom}), xs[i], vs[i],
               pick_value(), im, sg);
        sent += 2 * n;
      end else begin
        send($urandom_range(0, 1), $urandom_range(0, 1), 48'({$urandom, $urandom}),
             $urandom, $urandom, $urandom, $urandom, $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // reset values: noise due at once with zero drift
    send(0, 0, 0, 1000, -2000, 3000, 65536, 65536);
    send(1, 1, 100, 5, 6, 7, 65536, 65536);
    send(1, 0, 0, -5, -6, -7, 65536, 65536);
    wait_drained();

    write_all(32'd65536, 32'd1, 32'd655, 32'd65536, 32'd131072);
    send(0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1);
    send(0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1);
    send(0, 1, 48'hFFFF_FFFF_FFFF, 100, 200, 300, 0, 32'hFFFF_FFFF);
    // noise due; zero sigma saturates the weight
    send(1, 1, 48'h10_0000, 10, 20, 30, 65536, 0);
    send(1, 0, 0, 10, 20, 30, 65536, 1);
    send(1, 0, 0, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // delay not yet passed, then time going backward
    send(1, 1, 48'h10_0001, 1, 2, 3, 65536, 65536);
    send(1, 1, 48'h5, 1, 2, 3, 65536, 65536);
    send(1, 0, 0, 1, 2, 3, 65536, 65536);
    wait_drained();

    // zero temperature disables noise
    write_all(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send(1, 1, 48'hFFFF_FFFF_FFFF, 7, 8, 9, 65536, 65536);
    wait_drained();
    // huge product saturates the noise scale
    write_reg(REG_TEMPERATURE, 32'hFFFF_FFFF);
    send(1, 1, 48'hFFFF_FFFF_FFFF, 7, 8, 9, 65536, 65536);
    send(1, 0, 0, 7, -8, 9, 65536, 32'h100);
    wait_drained();
    sim_now = 0;

    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      idle_mode = 0;
      case (ph)
        0: write_all(32'd655, 32'd1638, 32'd65536, 32'd65536, 32'd0);
        1: write_all('1, '1, '1, '1, '1);
        2: write_all(0, 0, 0, 0, 0);
        3: write_all($urandom_range(0, 1 << 18), $urandom, $urandom_range(0, 1 << 20),
                     $urandom_range(0, 1 << 24), $urandom_range(0, 1 << 20));
        4: write_all($urandom, $urandom, $urandom, $urandom, $urandom);
        default: write_all(32'd1311, 32'd65536, 32'd6553, 32'd1 << 20, 32'd1 << 18);
      endcase
      sim_now = 0;
      idle_mode = ph % 4;
      random_phase(92, ph == 2);
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
